@@ rtl/ptct_pkg.sv @@
package ptct_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int ID_W = 24;
  localparam int CNT_W = 8;
  localparam int ST_W = 3;

  localparam logic OP_CREATE = 1'b0;
  localparam logic OP_COMPLETE = 1'b1;

  localparam logic [ST_W-1:0] ST_CREATED = 3'd0;
  localparam logic [ST_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL = 3'd2;
  localparam logic [ST_W-1:0] ST_PENDING = 3'd3;
  localparam logic [ST_W-1:0] ST_COMPLETED = 3'd4;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd5;

  typedef struct packed {
    logic opcode;
    logic [ID_W-1:0] task_id;
    logic [ID_W-1:0] alternate_id;
    logic [CNT_W-1:0] num_actions;
  } in_item_t;

  typedef struct packed {
    logic [ST_W-1:0] status;
    logic [ID_W-1:0] result_id;
  } out_item_t;

  typedef struct packed {
    logic load_in;
    logic exec;
  } ctrl_cmd_t;

endpackage

@@ rtl/ptct_ctrl.sv @@
module ptct_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output ptct_pkg::ctrl_cmd_t cmd
);
  import ptct_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  // result register can take a new item if empty or drained this cycle
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd.load_in = 1'b0;
    cmd.exec = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          cmd.exec = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/ptct_dp.sv @@
module ptct_dp (
  input  logic clk,
  input  logic rst_n,
  input  ptct_pkg::ctrl_cmd_t cmd,
  input  ptct_pkg::in_item_t in_data,
  output ptct_pkg::out_item_t out_data
);
  import ptct_pkg::*;

  in_item_t in_r;
  out_item_t out_r, out_nxt;

  logic [ID_W-1:0] entry_id_r [TABLE_ENTRIES];
  logic [CNT_W-1:0] entry_rem_r [TABLE_ENTRIES];

  logic [ID_W-1:0] key;
  logic [TABLE_ENTRIES-1:0] match_vec, free_vec;
  logic match_hit, free_hit;
  logic [IDX_W-1:0] match_idx, free_idx;
  logic [CNT_W-1:0] rem;
  logic do_create, do_free, do_dec;

  // create uses the alternate id when task id is zero
  always_comb begin
    if (in_r.opcode == OP_CREATE && in_r.task_id == '0) begin
      key = in_r.alternate_id;
    end else begin
      key = in_r.task_id;
    end
  end

  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      match_vec[i] = (key != '0) && (entry_id_r[i] == key);
      free_vec[i] = (entry_id_r[i] == '0);
    end
  end

  // lowest set bit wins
  always_comb begin
    match_idx = '0;
    free_idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (match_vec[i]) match_idx = IDX_W'(i);
      if (free_vec[i]) free_idx = IDX_W'(i);
    end
  end

  assign match_hit = |match_vec;
  assign free_hit = |free_vec;
  assign rem = entry_rem_r[match_idx];

  always_comb begin
    do_create = 1'b0;
    do_free = 1'b0;
    do_dec = 1'b0;
    out_nxt.result_id = '0;
    if (in_r.opcode == OP_CREATE) begin
      if (key == '0 || match_hit) begin
        out_nxt.status = ST_DUPLICATE;
      end else if (!free_hit) begin
        out_nxt.status = ST_FULL;
      end else begin
        out_nxt.status = ST_CREATED;
        out_nxt.result_id = key;
        do_create = 1'b1;
      end
    end else begin
      if (!match_hit) begin
        out_nxt.status = ST_NOTFOUND;
      end else if (rem <= CNT_W'(1)) begin
        out_nxt.status = ST_COMPLETED;
        out_nxt.result_id = key;
        do_free = 1'b1;
      end else begin
        out_nxt.status = ST_PENDING;
        do_dec = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_data;
    end
    if (cmd.exec) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        entry_id_r[i] <= '0;
        entry_rem_r[i] <= '0;
      end
    end else if (cmd.exec) begin
      if (do_create) begin
        entry_id_r[free_idx] <= key;
        entry_rem_r[free_idx] <= in_r.num_actions;
      end else if (do_free) begin
        entry_id_r[match_idx] <= '0;
        entry_rem_r[match_idx] <= '0;
      end else if (do_dec) begin
        entry_rem_r[match_idx] <= rem - CNT_W'(1);
      end
    end
  end

  assign out_data = out_r;

endmodule

@@ rtl/pending_task_completion_table.sv @@
// pending task completion table
// input channel (in_valid/in_ready/in_data) carries create and complete items;
// every item gives exactly one result item on out_valid/out_ready/out_data.
// a create stores the id (task id, or the alternate id when task id is zero)
// in the lowest free entry unless the id is zero or already held, or the table is full.
// a complete takes one action off the matching entry and frees it when the
// count runs out, reporting the task id.
// timing: an item is taken into the input register in the idle state and is
// resolved in the exec state, where all entries are compared in parallel, the
// entry is written back and the result register is loaded, from which the
// result is shown. one item is in work at a time: none is taken while one resolves.
// the result register lets the next item be accepted while a result waits;
// if the receiver stalls, the following item waits in its resolve cycle until
// the result register drains, and in_ready stays low meanwhile.
// reset (rst_n, synchronous, active low) frees every entry at once and drops
// out_valid.
module pending_task_completion_table (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  ptct_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output ptct_pkg::out_item_t out_data
);
  import ptct_pkg::*;

  ctrl_cmd_t cmd;

  ptct_ctrl u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd(cmd)
  );

  ptct_dp u_dp (
    .clk(clk),
    .rst_n(rst_n),
    .cmd(cmd),
    .in_data(in_data),
    .out_data(out_data)
  );

  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while another is in work");

  a_exec_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid)
    else $error("resolved item did not reach the result register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> !(out_valid && !out_ready))
    else $error("result register overwritten while stalled");

  a_created_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_CREATED) |-> (out_data.result_id != '0))
    else $error("created result with zero id");

endmodule
